// File: rtl/assert_macros.svh
// Assertion macros shared by the lexer RTL.
// Depends on nothing; included by the top level only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that an implication holds at every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Check that an implication holds in the next cycle.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

// File: rtl/csl_pkg.sv
// Package for the C subset lexer: token codes, error codes, scan states, result type.
// Depends on nothing; used by every lexer module.
package csl_pkg;

    localparam int unsigned MaxLexeme    = 255;
    localparam int unsigned PositionBits = 16;
    localparam int unsigned KeywordCount = 8;
    localparam logic [3:0]  TabReset     = 4'd4;

    // Token kinds.
    localparam logic [4:0] TK_PLUS = 5'd8, TK_MINUS = 5'd9, TK_STAR = 5'd10,
        TK_SLASH = 5'd11, TK_IDENT = 5'd12, TK_NUMBER = 5'd13, TK_GT = 5'd14,
        TK_GE = 5'd15, TK_LT = 5'd16, TK_LE = 5'd17, TK_EQEQ = 5'd18,
        TK_LPAR = 5'd19, TK_RPAR = 5'd20, TK_LBRACE = 5'd21, TK_RBRACE = 5'd22,
        TK_COMMA = 5'd23, TK_SEMI = 5'd24, TK_ASSIGN = 5'd25, TK_NE = 5'd26,
        TK_CHARLIT = 5'd27, TK_NONE = 5'd0;

    // Error codes.
    localparam logic [2:0] ER_NONE = 3'd0, ER_DECIMAL = 3'd1, ER_COMMENT = 3'd2,
        ER_BANG = 3'd3, ER_LITERAL = 3'd4, ER_UNKNOWN = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE, S_IDENT, S_INT, S_DOT, S_FRAC, S_LT, S_GT, S_EQ, S_BANG,
        S_SLASH, S_LCOM, S_BCOM, S_BSTAR, S_QUOTE, S_QCHAR
    } t_scan;

    // Token result without positions' width dependence beyond the field widths.
    typedef struct packed {
        logic [4:0]  kind;
        logic [2:0]  err;
        logic [15:0] line;
        logic [15:0] col;
        logic [7:0]  len;
        logic [7:0]  lit;
        logic        last;
    } t_result;

    function automatic logic [2:0] kw_len(input logic [2:0] k);
        case (k)
            3'd0, 3'd5: kw_len = 3'd5;
            3'd1, 3'd4: kw_len = 3'd3;
            3'd2:       kw_len = 3'd2;
            default:    kw_len = 3'd4;
        endcase
    endfunction

    // Keyword character at position p of keyword k, zero past its end.
    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
        logic [47:0] s;
        case (k)
            3'd0: s = "while";
            3'd1: s = "for";
            3'd2: s = "if";
            3'd3: s = "else";
            3'd4: s = "int";
            3'd5: s = "float";
            3'd6: s = "char";
            default: s = "main";
        endcase
        kw_char = 8'd0;
        if (p < kw_len(k)) begin
            kw_char = s[8 * (kw_len(k) - 1 - p) +: 8];
        end
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
    endfunction
    function automatic logic is_digit(input logic [7:0] c);
        is_digit = c >= 8'h30 && c <= 8'h39;
    endfunction

endpackage

// File: rtl/csl_front.sv
// Front end of the lexer: scan state machine, position counters, result pairs.
// Depends on csl_pkg; feeds csl_queue.
module csl_front #(
    parameter int unsigned MAX_LEXEME    = csl_pkg::MaxLexeme,
    parameter int unsigned POSITION_BITS = csl_pkg::PositionBits
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_char_code,
    input  logic                i_end_of_input,
    input  logic [3:0]          i_tab,
    output logic [1:0]          o_count,
    output csl_pkg::t_result    o_res0,
    output csl_pkg::t_result    o_res1
);
    localparam int unsigned LenBits = $clog2(MAX_LEXEME + 1);
    localparam logic [POSITION_BITS-1:0] PosMax = '1;
    localparam logic [LenBits-1:0] LenMax = LenBits'(MAX_LEXEME);
    localparam int KeywordTop = csl_pkg::KeywordCount - 1;

    csl_pkg::t_scan r_state, n_state;
    logic [7:0] r_alive, n_alive;
    logic [LenBits-1:0] r_len, n_len;
    logic [7:0] r_lit, n_lit;
    logic [POSITION_BITS-1:0] r_line, n_line, r_col, n_col, r_tline, n_tline, r_tcol, n_tcol;
    logic r_halt, n_halt;

    logic [7:0] c;
    logic redo, alnum, space;
    logic [4:0] k0, k1;
    logic [2:0] e0, e1;
    logic [LenBits-1:0] l0, l1;
    logic [7:0] lit0;
    logic emit0, emit1;
    logic [POSITION_BITS:0] col_sum;

    // Keyword kind of the running identifier.
    function automatic logic [4:0] ident_kind(input logic [7:0] alive,
                                               input logic [LenBits-1:0] len);
        ident_kind = csl_pkg::TK_IDENT;
        for (int i = KeywordTop; i >= 0; i--) begin
            if (alive[i] && len == LenBits'(csl_pkg::kw_len(3'(i)))) begin
                ident_kind = 5'(i);
            end
        end
    endfunction

    // Survivor mask after seeing byte ch at position len.
    function automatic logic [7:0] filter(input logic [7:0] alive,
                                          input logic [LenBits-1:0] len,
                                          input logic [7:0] ch);
        filter = alive;
        for (int i = 0; i < csl_pkg::KeywordCount; i++) begin
            if (len > LenBits'(5) || csl_pkg::kw_char(3'(i), len[2:0]) != ch) begin
                filter[i] = 1'b0;
            end
        end
    endfunction

    function automatic logic [LenBits-1:0] grow(input logic [LenBits-1:0] len);
        grow = (len < LenMax) ? len + 1'b1 : len;
    endfunction

    function automatic logic [7:0] cap8(input logic [LenBits-1:0] len);
        logic [31:0] w;
        w = 32'(len);
        cap8 = (w > 32'd255) ? 8'hff : w[7:0];
    endfunction

    function automatic logic [15:0] cap16(input logic [POSITION_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        cap16 = (w > 32'h0000_ffff) ? 16'hffff : w[15:0];
    endfunction

    // Next scan state and emitted results.
    always_comb begin
        c = i_char_code;
        alnum = csl_pkg::is_alpha(c) || csl_pkg::is_digit(c);
        space = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
        n_state = r_state; n_alive = r_alive; n_len = r_len; n_lit = r_lit;
        n_tline = r_tline; n_tcol = r_tcol; n_halt = r_halt;
        n_line = r_line; n_col = r_col;
        emit0 = 1'b0; k0 = csl_pkg::TK_NONE; e0 = csl_pkg::ER_NONE; l0 = '0; lit0 = 8'd0;
        emit1 = 1'b0; k1 = csl_pkg::TK_NONE; e1 = csl_pkg::ER_NONE; l1 = '0;
        redo = 1'b0;
        col_sum = '0;
        if (i_end_of_input) begin
            emit0 = 1'b1;
            case (r_state)
                csl_pkg::S_IDENT: begin k0 = ident_kind(r_alive, r_len); l0 = r_len; end
                csl_pkg::S_INT, csl_pkg::S_FRAC: begin k0 = csl_pkg::TK_NUMBER; l0 = r_len; end
                csl_pkg::S_DOT: e0 = csl_pkg::ER_DECIMAL;
                csl_pkg::S_LT: begin k0 = csl_pkg::TK_LT; l0 = LenBits'(1); end
                csl_pkg::S_GT: begin k0 = csl_pkg::TK_GT; l0 = LenBits'(1); end
                csl_pkg::S_EQ: begin k0 = csl_pkg::TK_ASSIGN; l0 = LenBits'(1); end
                csl_pkg::S_BANG: e0 = csl_pkg::ER_BANG;
                csl_pkg::S_SLASH: begin k0 = csl_pkg::TK_SLASH; l0 = LenBits'(1); end
                csl_pkg::S_BCOM, csl_pkg::S_BSTAR: e0 = csl_pkg::ER_COMMENT;
                csl_pkg::S_QUOTE, csl_pkg::S_QCHAR: e0 = csl_pkg::ER_LITERAL;
                default: emit0 = 1'b0;
            endcase
            n_state = csl_pkg::S_IDLE; n_alive = 8'hff; n_len = '0;
            n_line = POSITION_BITS'(1); n_col = POSITION_BITS'(1);
        end else begin
            case (r_state)
                csl_pkg::S_IDENT: begin
                    if (alnum || c == 8'h5f) begin
                        n_alive = filter(r_alive, r_len, c); n_len = grow(r_len);
                    end else begin
                        emit0 = 1'b1; k0 = ident_kind(r_alive, r_len); l0 = r_len; redo = 1'b1;
                    end
                end
                csl_pkg::S_INT: begin
                    if (csl_pkg::is_digit(c)) n_len = grow(r_len);
                    else if (c == 8'h2e) begin
                        n_len = grow(r_len); n_state = csl_pkg::S_DOT;
                    end else begin
                        emit0 = 1'b1; k0 = csl_pkg::TK_NUMBER; l0 = r_len; redo = 1'b1;
                    end
                end
                csl_pkg::S_DOT: begin
                    if (csl_pkg::is_digit(c)) begin
                        n_len = grow(r_len); n_state = csl_pkg::S_FRAC;
                    end else begin
                        emit0 = 1'b1; e0 = csl_pkg::ER_DECIMAL;
                    end
                end
                csl_pkg::S_FRAC: begin
                    if (csl_pkg::is_digit(c)) n_len = grow(r_len);
                    else begin
                        emit0 = 1'b1; k0 = csl_pkg::TK_NUMBER; l0 = r_len; redo = 1'b1;
                    end
                end
                csl_pkg::S_LT, csl_pkg::S_GT, csl_pkg::S_EQ: begin
                    emit0 = 1'b1;
                    if (c == 8'h3d) begin
                        l0 = LenBits'(2); n_state = csl_pkg::S_IDLE;
                        k0 = (r_state == csl_pkg::S_LT) ? csl_pkg::TK_LE :
                             (r_state == csl_pkg::S_GT) ? csl_pkg::TK_GE : csl_pkg::TK_EQEQ;
                    end else begin
                        l0 = LenBits'(1); redo = 1'b1;
                        k0 = (r_state == csl_pkg::S_LT) ? csl_pkg::TK_LT :
                             (r_state == csl_pkg::S_GT) ? csl_pkg::TK_GT : csl_pkg::TK_ASSIGN;
                    end
                end
                csl_pkg::S_BANG: begin
                    emit0 = 1'b1;
                    if (c == 8'h3d) begin
                        k0 = csl_pkg::TK_NE; l0 = LenBits'(2); n_state = csl_pkg::S_IDLE;
                    end else e0 = csl_pkg::ER_BANG;
                end
                csl_pkg::S_SLASH: begin
                    if (c == 8'h2f) n_state = csl_pkg::S_LCOM;
                    else if (c == 8'h2a) n_state = csl_pkg::S_BCOM;
                    else begin
                        emit0 = 1'b1; k0 = csl_pkg::TK_SLASH; l0 = LenBits'(1); redo = 1'b1;
                    end
                end
                csl_pkg::S_LCOM: if (c == 8'h0a) n_state = csl_pkg::S_IDLE;
                csl_pkg::S_BCOM: if (c == 8'h2a) n_state = csl_pkg::S_BSTAR;
                csl_pkg::S_BSTAR: begin
                    if (c == 8'h2f) n_state = csl_pkg::S_IDLE;
                    else if (c != 8'h2a) n_state = csl_pkg::S_BCOM;
                end
                csl_pkg::S_QUOTE: begin
                    if (alnum) begin
                        n_lit = c; n_state = csl_pkg::S_QCHAR;
                    end else begin
                        emit0 = 1'b1; e0 = csl_pkg::ER_LITERAL;
                    end
                end
                csl_pkg::S_QCHAR: begin
                    emit0 = 1'b1;
                    if (c == 8'h27) begin
                        k0 = csl_pkg::TK_CHARLIT; l0 = LenBits'(3); lit0 = r_lit;
                        n_state = csl_pkg::S_IDLE;
                    end else e0 = csl_pkg::ER_LITERAL;
                end
                default: redo = 1'b1;
            endcase

            // Start of a new token on this byte.
            if (redo) begin
                n_state = csl_pkg::S_IDLE;
                if (!space) begin
                    n_tline = r_line; n_tcol = r_col; n_len = '0;
                    if (csl_pkg::is_alpha(c) || c == 8'h5f) begin
                        n_alive = filter(8'hff, '0, c); n_len = grow('0);
                        n_state = csl_pkg::S_IDENT;
                    end else if (csl_pkg::is_digit(c)) begin
                        n_len = grow('0); n_state = csl_pkg::S_INT;
                    end else begin
                        emit1 = 1'b1; l1 = LenBits'(1);
                        case (c)
                            8'h3c: begin emit1 = 1'b0; n_state = csl_pkg::S_LT; end
                            8'h3e: begin emit1 = 1'b0; n_state = csl_pkg::S_GT; end
                            8'h3d: begin emit1 = 1'b0; n_state = csl_pkg::S_EQ; end
                            8'h21: begin emit1 = 1'b0; n_state = csl_pkg::S_BANG; end
                            8'h2f: begin emit1 = 1'b0; n_state = csl_pkg::S_SLASH; end
                            8'h27: begin emit1 = 1'b0; n_state = csl_pkg::S_QUOTE; end
                            8'h2b: k1 = csl_pkg::TK_PLUS;
                            8'h2d: k1 = csl_pkg::TK_MINUS;
                            8'h2a: k1 = csl_pkg::TK_STAR;
                            8'h28: k1 = csl_pkg::TK_LPAR;
                            8'h29: k1 = csl_pkg::TK_RPAR;
                            8'h7b: k1 = csl_pkg::TK_LBRACE;
                            8'h7d: k1 = csl_pkg::TK_RBRACE;
                            8'h2c: k1 = csl_pkg::TK_COMMA;
                            8'h3b: k1 = csl_pkg::TK_SEMI;
                            default: begin e1 = csl_pkg::ER_UNKNOWN; l1 = '0; end
                        endcase
                    end
                end
            end

            // Position update.
            if (c == 8'h0a) begin
                n_line = (r_line == PosMax) ? r_line : r_line + 1'b1;
                n_col = POSITION_BITS'(1);
            end else begin
                col_sum = {1'b0, r_col} + ((c == 8'h09) ? (POSITION_BITS+1)'(i_tab)
                                                        : (POSITION_BITS+1)'(1));
                n_col = col_sum[POSITION_BITS] ? PosMax : col_sum[POSITION_BITS-1:0];
            end
        end
        if ((emit0 && e0 != csl_pkg::ER_NONE) || (emit1 && e1 != csl_pkg::ER_NONE)) begin
            n_halt = 1'b1;
        end
    end

    // Result pair formatting; the second result carries the new start position.
    always_comb begin
        o_res0 = '0; o_res1 = '0;
        o_res0.kind = (e0 != csl_pkg::ER_NONE) ? csl_pkg::TK_NONE : k0;
        o_res0.err  = e0;
        o_res0.line = cap16(r_tline);
        o_res0.col  = cap16(r_tcol);
        o_res0.len  = (e0 != csl_pkg::ER_NONE) ? 8'd0 : cap8(l0);
        o_res0.lit  = lit0;
        o_res0.last = !emit1;
        o_res1.kind = (e1 != csl_pkg::ER_NONE) ? csl_pkg::TK_NONE : k1;
        o_res1.err  = e1;
        o_res1.line = cap16(r_line);
        o_res1.col  = cap16(r_col);
        o_res1.len  = (e1 != csl_pkg::ER_NONE) ? 8'd0 : cap8(l1);
        o_res1.lit  = 8'd0;
        o_res1.last = 1'b1;
        if (emit0 && emit1) o_count = 2'd2;
        else if (emit0 || emit1) o_count = 2'd1;
        else o_count = 2'd0;
        if (!emit0) o_res0 = o_res1;
        if (!i_step || r_halt) o_count = 2'd0;
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csl_pkg::S_IDLE; r_alive <= 8'hff; r_len <= '0; r_lit <= 8'd0;
            r_line <= POSITION_BITS'(1); r_col <= POSITION_BITS'(1);
            r_tline <= POSITION_BITS'(1); r_tcol <= POSITION_BITS'(1);
            r_halt <= 1'b0;
        end else if (i_step && !r_halt) begin
            r_state <= n_state; r_alive <= n_alive; r_len <= n_len; r_lit <= n_lit;
            r_line <= n_line; r_col <= n_col; r_tline <= n_tline; r_tcol <= n_tcol;
            r_halt <= n_halt;
        end
    end
endmodule

// File: rtl/csl_queue.sv
// Result queue of the lexer: takes up to two results a cycle, gives one.
// Depends on csl_pkg; sits between csl_front and the result ports.
module csl_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_count,
    input  csl_pkg::t_result i_res0,
    input  csl_pkg::t_result i_res1,
    input  logic             i_pop,
    output logic             o_empty,
    output logic             o_room,
    output csl_pkg::t_result o_head
);
    localparam int Depth = 8;
    csl_pkg::t_result r_mem [Depth];
    logic [2:0] r_wp, r_rp, n_wp, n_rp;
    logic [3:0] r_cnt, n_cnt;
    logic do_pop;

    // Pointer and fill arithmetic.
    always_comb begin
        do_pop = i_pop && (r_cnt != 4'd0);
        n_wp = r_wp + 3'(i_count);
        n_rp = r_rp + 3'(do_pop);
        n_cnt = r_cnt + 4'(i_count) - 4'(do_pop);
    end
    assign o_empty = (r_cnt == 4'd0);
    assign o_room  = (r_cnt <= 4'd6);
    assign o_head  = r_mem[r_rp];

    // Storage writes.
    always_ff @(posedge i_clk) begin
        if (i_count != 2'd0) r_mem[r_wp] <= i_res0;
        if (i_count == 2'd2) r_mem[r_wp + 3'd1] <= i_res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp <= n_wp; r_rp <= n_rp; r_cnt <= n_cnt;
        end
    end
endmodule

// File: rtl/c_subset_lexer_core.sv
// Top level of the C subset lexer: tab register, front end and result queue.
// Depends on csl_pkg, csl_front, csl_queue and assert_macros.svh.
// The lexer takes one source byte each cycle while full is low; every byte is
// classified by the scan state machine, which yields up to two
// tokens, written into an eight-entry result queue drained one per pop. full
// rises when the queue has fewer than two free entries. An error token halts
// the lexer until reset; later bytes are taken and dropped.
`include "assert_macros.svh"
module c_subset_lexer_core #(
    parameter int unsigned MAX_LEXEME    = csl_pkg::MaxLexeme,
    parameter int unsigned POSITION_BITS = csl_pkg::PositionBits
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_input,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  o_token_kind,
    output logic [2:0]  o_error_code,
    output logic [15:0] o_start_line,
    output logic [15:0] o_start_column,
    output logic [7:0]  o_lexeme_length,
    output logic [7:0]  o_literal_char,
    output logic        o_last_of_run,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data
);
    logic [3:0] r_tab;
    logic step, room;
    logic [1:0] cnt;
    csl_pkg::t_result res0, res1, head;

    // Tab width register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tab <= csl_pkg::TabReset;
        else if (i_cfg_we) r_tab <= i_cfg_data;
    end

    assign full = !room;
    assign step = push && room;

    csl_front #(.MAX_LEXEME(MAX_LEXEME), .POSITION_BITS(POSITION_BITS)) u_front (
        .i_clk, .i_rst_n, .i_step(step), .i_char_code, .i_end_of_input,
        .i_tab(r_tab), .o_count(cnt), .o_res0(res0), .o_res1(res1)
    );

    csl_queue u_queue (
        .i_clk, .i_rst_n, .i_count(cnt), .i_res0(res0), .i_res1(res1),
        .i_pop(pop), .o_empty(empty), .o_room(room), .o_head(head)
    );

    assign o_token_kind    = head.kind;
    assign o_error_code    = head.err;
    assign o_start_line    = head.line;
    assign o_start_column  = head.col;
    assign o_lexeme_length = head.len;
    assign o_literal_char  = head.lit;
    assign o_last_of_run   = head.last;

    // Results only appear after an accepted byte.
    `CHK_IMPL(a_cnt_step, i_clk, i_rst_n, !step, cnt == 2'd0)
    // An error result on the first slot is the last of its step.
    `CHK_IMPL(a_err_last, i_clk, i_rst_n, cnt == 2'd2, res0.err == csl_pkg::ER_NONE)
    // A result written to an empty queue is visible next cycle.
    `CHK_NEXT(a_fill, i_clk, i_rst_n, empty && cnt != 2'd0, !empty)
endmodule

// File: dv/testbench.sv
// Self-checking testbench for c_subset_lexer_core: directed rows, a length saturation run
// and constrained random token streams, all checked against an in-bench token predictor.
// Depends on csl_pkg and the lexer RTL.
module testbench;

    localparam int CycleLimit = 100000;
    localparam int RandomItems = 900;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_char_code;
    logic        i_end_of_input;
    logic        empty;
    logic        pop;
    logic [4:0]  o_token_kind;
    logic [2:0]  o_error_code;
    logic [15:0] o_start_line;
    logic [15:0] o_start_column;
    logic [7:0]  o_lexeme_length;
    logic [7:0]  o_literal_char;
    logic        o_last_of_run;
    logic        i_cfg_we;
    logic [3:0]  i_cfg_data;

    c_subset_lexer_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_char_code(i_char_code), .i_end_of_input(i_end_of_input),
        .empty(empty), .pop(pop), .o_token_kind(o_token_kind),
        .o_error_code(o_error_code), .o_start_line(o_start_line),
        .o_start_column(o_start_column), .o_lexeme_length(o_lexeme_length),
        .o_literal_char(o_literal_char), .o_last_of_run(o_last_of_run),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    // Tokens still owed by the lexer, oldest first.
    csl_pkg::t_result token_q[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          bytes_sent = 0;
    bit          calm = 1'b1;

    // First token of a directed row and the latest predicted token.
    csl_pkg::t_result first_tok;
    csl_pkg::t_result last_tok;
    bit          first_wait = 1'b0;

    // Predictor state.
    csl_pkg::t_scan scan;
    logic [7:0]  kw_alive;
    int          lex_len;
    logic [7:0]  held_char;
    int          line_no;
    int          col_no;
    int          tok_line;
    int          tok_col;
    bit          stopped;
    int          tab_cols;

    string       kwords[8] = '{"while", "for", "if", "else", "int", "float", "char", "main"};

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Timeout watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("** c_subset_lexer_core: FAILED **");
            $finish;
        end
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        fail_count++;
    endtask

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction
    function automatic bit is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void add_token(input logic [4:0] kind, input logic [2:0] err,
                                      input int len, input logic [7:0] lit);
        csl_pkg::t_result r;
        r.kind = (err != csl_pkg::ER_NONE) ? csl_pkg::TK_NONE : kind;
        r.err  = err;
        r.line = tok_line[15:0];
        r.col  = tok_col[15:0];
        r.len  = (err != csl_pkg::ER_NONE) ? 8'd0 : ((len > 255) ? 8'd255 : len[7:0]);
        r.lit  = lit;
        r.last = 1'b0;
        token_q.push_back(r);
        last_tok = r;
        if (first_wait) begin
            first_tok = r;
            first_wait = 1'b0;
        end
        if (err != csl_pkg::ER_NONE) stopped = 1'b1;
    endfunction

    function automatic void narrow_keywords(input logic [7:0] c);
        for (int i = 0; i < 8; i++) begin
            if (!(lex_len < kwords[i].len() && kwords[i][lex_len] == c)) kw_alive[i] = 1'b0;
        end
    endfunction

    function automatic logic [4:0] word_kind();
        for (int i = 0; i < 8; i++) begin
            if (kw_alive[i] && lex_len == kwords[i].len()) return i[4:0];
        end
        return csl_pkg::TK_IDENT;
    endfunction

    function automatic void lengthen();
        if (lex_len < csl_pkg::MaxLexeme) lex_len++;
    endfunction

    // A byte seen between tokens: may open a token or be a one-byte token itself.
    function automatic void open_token(input logic [7:0] c, input int bl, input int bc);
        scan = csl_pkg::S_IDLE;
        if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) return;
        tok_line = bl;
        tok_col  = bc;
        lex_len  = 0;
        if (is_letter(c) || c == "_") begin
            kw_alive = 8'hff;
            narrow_keywords(c);
            lengthen();
            scan = csl_pkg::S_IDENT;
        end else if (is_num(c)) begin
            lengthen();
            scan = csl_pkg::S_INT;
        end else begin
            case (c)
                "<":  scan = csl_pkg::S_LT;
                ">":  scan = csl_pkg::S_GT;
                "=":  scan = csl_pkg::S_EQ;
                "!":  scan = csl_pkg::S_BANG;
                "/":  scan = csl_pkg::S_SLASH;
                "'":  scan = csl_pkg::S_QUOTE;
                "+":  add_token(csl_pkg::TK_PLUS, csl_pkg::ER_NONE, 1, 0);
                "-":  add_token(csl_pkg::TK_MINUS, csl_pkg::ER_NONE, 1, 0);
                "*":  add_token(csl_pkg::TK_STAR, csl_pkg::ER_NONE, 1, 0);
                "(":  add_token(csl_pkg::TK_LPAR, csl_pkg::ER_NONE, 1, 0);
                ")":  add_token(csl_pkg::TK_RPAR, csl_pkg::ER_NONE, 1, 0);
                "{":  add_token(csl_pkg::TK_LBRACE, csl_pkg::ER_NONE, 1, 0);
                "}":  add_token(csl_pkg::TK_RBRACE, csl_pkg::ER_NONE, 1, 0);
                ",":  add_token(csl_pkg::TK_COMMA, csl_pkg::ER_NONE, 1, 0);
                ";":  add_token(csl_pkg::TK_SEMI, csl_pkg::ER_NONE, 1, 0);
                default: add_token(csl_pkg::TK_NONE, csl_pkg::ER_UNKNOWN, 0, 0);
            endcase
        end
    endfunction

    // Predict the tokens caused by one accepted transaction.
    function automatic void lex_predict(input logic [7:0] c, input logic eoi);
        int  q_mark;
        int  bl;
        int  bc;
        bit  redo;
        q_mark = token_q.size();
        if (stopped) return;
        if (eoi) begin
            case (scan)
                csl_pkg::S_IDENT: add_token(word_kind(), csl_pkg::ER_NONE, lex_len, 0);
                csl_pkg::S_INT, csl_pkg::S_FRAC:
                    add_token(csl_pkg::TK_NUMBER, csl_pkg::ER_NONE, lex_len, 0);
                csl_pkg::S_DOT:   add_token(csl_pkg::TK_NONE, csl_pkg::ER_DECIMAL, 0, 0);
                csl_pkg::S_LT:    add_token(csl_pkg::TK_LT, csl_pkg::ER_NONE, 1, 0);
                csl_pkg::S_GT:    add_token(csl_pkg::TK_GT, csl_pkg::ER_NONE, 1, 0);
                csl_pkg::S_EQ:    add_token(csl_pkg::TK_ASSIGN, csl_pkg::ER_NONE, 1, 0);
                csl_pkg::S_BANG:  add_token(csl_pkg::TK_NONE, csl_pkg::ER_BANG, 0, 0);
                csl_pkg::S_SLASH: add_token(csl_pkg::TK_SLASH, csl_pkg::ER_NONE, 1, 0);
                csl_pkg::S_BCOM, csl_pkg::S_BSTAR:
                    add_token(csl_pkg::TK_NONE, csl_pkg::ER_COMMENT, 0, 0);
                csl_pkg::S_QUOTE, csl_pkg::S_QCHAR:
                    add_token(csl_pkg::TK_NONE, csl_pkg::ER_LITERAL, 0, 0);
                default: ;
            endcase
            scan = csl_pkg::S_IDLE;
            kw_alive = 8'hff;
            lex_len = 0;
            line_no = 1;
            col_no = 1;
        end else begin
            bl = line_no;
            bc = col_no;
            redo = 1'b0;
            case (scan)
                csl_pkg::S_IDENT:
                    if (is_letter(c) || is_num(c) || c == "_") begin
                        narrow_keywords(c);
                        lengthen();
                    end else begin
                        add_token(word_kind(), csl_pkg::ER_NONE, lex_len, 0);
                        redo = 1'b1;
                    end
                csl_pkg::S_INT:
                    if (is_num(c)) lengthen();
                    else if (c == ".") begin
                        lengthen();
                        scan = csl_pkg::S_DOT;
                    end else begin
                        add_token(csl_pkg::TK_NUMBER, csl_pkg::ER_NONE, lex_len, 0);
                        redo = 1'b1;
                    end
                csl_pkg::S_DOT:
                    if (is_num(c)) begin
                        lengthen();
                        scan = csl_pkg::S_FRAC;
                    end else add_token(csl_pkg::TK_NONE, csl_pkg::ER_DECIMAL, 0, 0);
                csl_pkg::S_FRAC:
                    if (is_num(c)) lengthen();
                    else begin
                        add_token(csl_pkg::TK_NUMBER, csl_pkg::ER_NONE, lex_len, 0);
                        redo = 1'b1;
                    end
                csl_pkg::S_LT, csl_pkg::S_GT, csl_pkg::S_EQ:
                    if (c == "=") begin
                        add_token(scan == csl_pkg::S_LT ? csl_pkg::TK_LE :
                                  scan == csl_pkg::S_GT ? csl_pkg::TK_GE : csl_pkg::TK_EQEQ,
                                  csl_pkg::ER_NONE, 2, 0);
                        scan = csl_pkg::S_IDLE;
                    end else begin
                        add_token(scan == csl_pkg::S_LT ? csl_pkg::TK_LT :
                                  scan == csl_pkg::S_GT ? csl_pkg::TK_GT : csl_pkg::TK_ASSIGN,
                                  csl_pkg::ER_NONE, 1, 0);
                        redo = 1'b1;
                    end
                csl_pkg::S_BANG:
                    if (c == "=") begin
                        add_token(csl_pkg::TK_NE, csl_pkg::ER_NONE, 2, 0);
                        scan = csl_pkg::S_IDLE;
                    end else add_token(csl_pkg::TK_NONE, csl_pkg::ER_BANG, 0, 0);
                csl_pkg::S_SLASH:
                    if (c == "/") scan = csl_pkg::S_LCOM;
                    else if (c == "*") scan = csl_pkg::S_BCOM;
                    else begin
                        add_token(csl_pkg::TK_SLASH, csl_pkg::ER_NONE, 1, 0);
                        redo = 1'b1;
                    end
                csl_pkg::S_LCOM:  if (c == 8'd10) scan = csl_pkg::S_IDLE;
                csl_pkg::S_BCOM:  if (c == "*") scan = csl_pkg::S_BSTAR;
                csl_pkg::S_BSTAR:
                    if (c == "/") scan = csl_pkg::S_IDLE;
                    else if (c != "*") scan = csl_pkg::S_BCOM;
                csl_pkg::S_QUOTE:
                    if (is_letter(c) || is_num(c)) begin
                        held_char = c;
                        scan = csl_pkg::S_QCHAR;
                    end else add_token(csl_pkg::TK_NONE, csl_pkg::ER_LITERAL, 0, 0);
                csl_pkg::S_QCHAR:
                    if (c == "'") begin
                        add_token(csl_pkg::TK_CHARLIT, csl_pkg::ER_NONE, 3, held_char);
                        scan = csl_pkg::S_IDLE;
                    end else add_token(csl_pkg::TK_NONE, csl_pkg::ER_LITERAL, 0, 0);
                default: redo = 1'b1;
            endcase
            if (redo && !stopped) open_token(c, bl, bc);
            // Position counters saturate at the top of their range.
            if (c == 8'd10) begin
                line_no = (line_no < 65535) ? line_no + 1 : 65535;
                col_no = 1;
            end else if (c == 8'd9) begin
                col_no = (col_no + tab_cols > 65535) ? 65535 : col_no + tab_cols;
            end else begin
                col_no = (col_no < 65535) ? col_no + 1 : 65535;
            end
        end
        if (token_q.size() > q_mark) token_q[token_q.size() - 1].last = 1'b1;
    endfunction

    // Offer one transaction on the input side and predict it once accepted.
    task automatic put_byte(input logic [7:0] c, input logic eoi);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 35) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_char_code <= c;
        i_end_of_input <= eoi;
        do @(posedge i_clk); while (full);
        lex_predict(c, eoi);
        bytes_sent++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i], 1'b0);
    endtask

    task automatic put_end();
        put_byte($urandom_range(255), 1'b1);
    endtask

    // Wait until every owed token has arrived and the lexer has settled.
    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (token_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_tab(input logic [3:0] w);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= w;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tab_cols = w;
    endtask

    // Result side: random back-pressure unless calm, field-by-field comparison.
    always @(negedge i_clk) begin
        pop <= calm ? 1'b1 : ($urandom_range(99) >= 35);
    end

    always @(posedge i_clk) begin
        csl_pkg::t_result want;
        if (i_rst_n && pop && !empty) begin
            if (token_q.size() == 0) begin
                report("unexpected token kind", o_token_kind, -1);
            end else begin
                want = token_q.pop_front();
                if (o_token_kind != want.kind) report("token_kind", o_token_kind, want.kind);
                if (o_error_code != want.err) report("error_code", o_error_code, want.err);
                if (o_start_line != want.line) report("start_line", o_start_line, want.line);
                if (o_start_column != want.col)
                    report("start_column", o_start_column, want.col);
                if (o_lexeme_length != want.len)
                    report("lexeme_length", o_lexeme_length, want.len);
                if (o_literal_char != want.lit)
                    report("literal_char", o_literal_char, want.lit);
                if (o_last_of_run != want.last)
                    report("last_of_run", o_last_of_run, want.last);
            end
        end
    end

    // One well-formed random token or an end of input, with a separator where gluing could go wrong.
    task automatic put_random_token();
        string s;
        bit    sep;
        int    n;
        s = "";
        sep = 1'b0;
        case ($urandom_range(11))
            0: s = kwords[$urandom_range(7)];
            1: begin
                n = $urandom_range(1, 10);
                s = {s, string'(8'("_"))};
                if ($urandom_range(1)) s = kwords[$urandom_range(7)];
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(3))
                        0: s = {s, string'(8'($urandom_range("a", "z")))};
                        1: s = {s, string'(8'($urandom_range("A", "Z")))};
                        2: s = {s, string'(8'($urandom_range("0", "9")))};
                        default: s = {s, "_"};
                    endcase
                end
            end
            2, 3: begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range("0", "9")))};
                if ($urandom_range(1)) begin
                    s = {s, "."};
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++)
                        s = {s, string'(8'($urandom_range("0", "9")))};
                end
                sep = 1'b1;
            end
            4: begin
                s = "+-*(){},;";
                s = string'(s[$urandom_range(8)]);
            end
            5: begin
                case ($urandom_range(6))
                    0: s = "<";  1: s = "<=";  2: s = ">";  3: s = ">=";
                    4: s = "=";  5: s = "==";  default: s = "!=";
                endcase
                sep = 1'b1;
            end
            6: begin
                case ($urandom_range(2))
                    0: n = $urandom_range("a", "z");
                    1: n = $urandom_range("A", "Z");
                    default: n = $urandom_range("0", "9");
                endcase
                s = {"'", string'(8'(n)), "'"};
            end
            7: begin
                s = "//";
                repeat ($urandom_range(0, 8)) begin
                    n = $urandom_range(1, 255);
                    if (n == 10) n = 11;
                    s = {s, string'(8'(n))};
                end
                s = {s, "\n"};
            end
            8: begin
                s = "/*";
                repeat ($urandom_range(0, 8)) begin
                    n = $urandom_range(1, 255);
                    if (n == "*") n = 200;
                    s = {s, string'(8'(n))};
                end
                repeat ($urandom_range(1, 3)) s = {s, "*"};
                s = {s, "/"};
            end
            9: begin
                s = "/";
                sep = 1'b1;
            end
            10: begin
                put_end();
                return;
            end
            default: ;
        endcase
        put_text(s);
        if (sep || $urandom_range(2) == 0) begin
            n = $urandom_range(0, 6);
            put_byte(n == 6 ? 8'd32 : 8'(9 + n), 1'b0);
        end
    endtask

    typedef struct {
        string      src;
        bit         typed;
        logic [4:0] kind;
        logic [7:0] len;
    } t_row;

    // Directed rows, each closed by end of input; typed rows check the first token.
    t_row rows[] = '{
        '{"while for if else int float char main", 1'b1, 5'd0, 8'd5},
        '{"_x9 whilex fo mains", 1'b1, csl_pkg::TK_IDENT, 8'd3},
        '{"0 123 4.56 7.0", 1'b1, csl_pkg::TK_NUMBER, 8'd1},
        '{"+-*/(){},;", 1'b1, csl_pkg::TK_PLUS, 8'd1},
        '{"< <= > >= = == != <x", 1'b1, csl_pkg::TK_LT, 8'd1},
        '{"'a' 'Z' '7'", 1'b1, csl_pkg::TK_CHARLIT, 8'd3},
        '{"a//c\nb", 1'b0, 5'd0, 8'd0},
        '{"a/*x**/b/***/c", 1'b0, 5'd0, 8'd0},
        '{"<", 1'b1, csl_pkg::TK_LT, 8'd1},
        '{">", 1'b1, csl_pkg::TK_GT, 8'd1},
        '{"=", 1'b1, csl_pkg::TK_ASSIGN, 8'd1},
        '{"/", 1'b1, csl_pkg::TK_SLASH, 8'd1},
        '{"12.5", 1'b1, csl_pkg::TK_NUMBER, 8'd4},
        '{"x\t\ty", 1'b0, 5'd0, 8'd0},
        '{"\015\n\n\f\vz", 1'b0, 5'd0, 8'd0},
        '{"", 1'b0, 5'd0, 8'd0}
    };

    initial begin
        string  err_src;
        int     err_pick;
        int     mark;
        push = 1'b0;
        pop = 1'b0;
        i_char_code = 8'd0;
        i_end_of_input = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = 4'd0;
        i_rst_n = 1'b0;
        scan = csl_pkg::S_IDLE;
        kw_alive = 8'hff;
        lex_len = 0;
        held_char = 8'd0;
        line_no = 1;
        col_no = 1;
        tok_line = 1;
        tok_col = 1;
        stopped = 1'b0;
        tab_cols = csl_pkg::TabReset;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, first at the reset tab width.
        calm = 1'b0;
        foreach (rows[r]) begin
            first_wait = 1'b1;
            for (int i = 0; i < rows[r].src.len(); i++) put_byte(rows[r].src[i], 1'b0);
            put_end();
            if (rows[r].typed && !first_wait) begin
                if (first_tok.kind != rows[r].kind)
                    report("typed token_kind", first_tok.kind, rows[r].kind);
                if (first_tok.len != rows[r].len)
                    report("typed lexeme_length", first_tok.len, rows[r].len);
            end
            first_wait = 1'b0;
        end
        // Longest identifier saturates the length field.
        repeat (300) put_byte("q", 1'b0);
        put_end();
        if (last_tok.len != 8'd255)
            report("typed saturated length", last_tok.len, 255);

        // Random streams over several tab widths; the first stretch has no idling.
        calm = 1'b1;
        set_tab(4'd0);
        mark = bytes_sent;
        while (bytes_sent - mark < RandomItems / 4) put_random_token();
        calm = 1'b0;
        // Hold the sender off until everything owed has been popped.
        drain();
        set_tab(4'($urandom_range(1, 14)));
        while (bytes_sent - mark < RandomItems / 2) put_random_token();
        set_tab(4'd15);
        while (bytes_sent - mark < 3 * RandomItems / 4) put_random_token();
        set_tab(csl_pkg::TabReset);
        while (bytes_sent - mark < RandomItems) put_random_token();

        // One error case closes the run, since an error halts the lexer for good.
        err_pick = $urandom_range(8);
        case (err_pick)
            0: err_src = "1.x";
            1: err_src = "/* open";
            2: err_src = "!x";
            3: err_src = "'+";
            4: err_src = "'ab";
            5: err_src = "'a";
            6: err_src = "@";
            7: err_src = ".";
            default: err_src = string'(8'd200);
        endcase
        put_text(err_src);
        put_end();
        if (last_tok.err == csl_pkg::ER_NONE)
            report("typed error_code", 0, 1);
        // Bytes after the error are taken and dropped.
        repeat (10) put_byte($urandom_range(255), 1'b0);
        put_text("int x;");

        drain();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("** c_subset_lexer_core: PASSED **");
        end else begin
            $display("** c_subset_lexer_core: FAILED **");
        end
        $finish;
    end
endmodule
